// ----- rtl/core/rmf_pkg.sv -----
// Shared constants, types and state codes of the rotating mask filter.
package rmf_pkg;

  localparam int MAX_WIDTH    = 2048;
  localparam int WIN          = 5;
  localparam int TAPS         = WIN * WIN;
  localparam int LINE_ROWS    = WIN - 1;
  localparam int PIX_W        = 24;
  localparam int LS_AW        = $clog2(MAX_WIDTH);
  localparam int HEIGHT_CAP   = 4096;
  localparam int LONE_VAR     = 100;
  localparam int MASK_COUNT   = 9;
  localparam int MASK_EDGE    = 3;
  localparam int Q_DEPTH      = 2;
  localparam int Q_AW         = $clog2(Q_DEPTH);
  localparam logic [11:0] WIDTH_RESET  = 12'd640;
  localparam logic [12:0] HEIGHT_RESET = 13'd480;

  // Register indexes on the configuration port.
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  // One filter job: the 5x5 neighborhood with out-of-image taps zeroed.
  typedef struct packed {
    logic                  last;
    pix_t [TAPS-1:0]       pix;
  } job_t;

  // Effective geometry and the frame restart strobe for the front end.
  typedef struct packed {
    logic [11:0] w;
    logic [12:0] h;
    logic        clr;
  } geom_t;

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_ACC  = 6'b000010,
    B_VAR  = 6'b000100,
    B_CMP  = 6'b001000,
    B_DIV  = 6'b010000,
    B_DONE = 6'b100000
  } back_state_t;

endpackage

// ----- rtl/core/rmf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/rmf_front.sv -----
// Front end: line store, 5x5 window, position tracking and job creation.
module rmf_front (
  input  logic           clk,
  input  logic           rst,
  input  rmf_pkg::geom_t geom,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           func,
  input  logic [7:0]     chan0,
  input  logic [7:0]     chan1,
  input  logic [7:0]     chan2,
  input  logic           q_full,
  output logic           push,
  output rmf_pkg::job_t  job
);

  localparam int LW = rmf_pkg::LINE_ROWS * rmf_pkg::PIX_W;

  logic [11:0] col;
  logic [12:0] row;
  logic        rd_ok;
  rmf_pkg::pix_t win [rmf_pkg::TAPS];
  rmf_pkg::pix_t win_next [rmf_pkg::TAPS];
  rmf_pkg::pix_t newcol [rmf_pkg::WIN];

  logic [11:0] colc;
  logic [12:0] col1;
  rmf_pkg::pix_t pix;
  logic [LW-1:0] ls_rd;
  logic          acc;
  logic signed [14:0] r, c, hs, ws;
  logic [rmf_pkg::WIN-1:0] rv, cv;
  logic has_res, beyond, is_last;

  assign in_ready = rd_ok && !q_full;
  assign acc      = in_valid && in_ready;
  assign colc     = (col >= geom.w) ? 12'd0 : col;
  assign pix      = (func || row >= geom.h) ? '0 : {chan2, chan1, chan0};

  // One word holds the four previous rows at a column; row 0 is the newest.
  rmf_ram #(.WIDTH(LW), .DEPTH(rmf_pkg::MAX_WIDTH)) u_line (
    .clk   (clk),
    .we    (acc),
    .waddr (rmf_pkg::LS_AW'(colc)),
    .wdata ({ls_rd[LW-rmf_pkg::PIX_W-1:0], pix}),
    .raddr (rmf_pkg::LS_AW'(colc)),
    .rdata (ls_rd)
  );

  always_comb begin
    newcol[0] = pix;
    for (int k = 1; k < rmf_pkg::WIN; k++) begin
      newcol[k] = ls_rd[(k-1)*rmf_pkg::PIX_W +: rmf_pkg::PIX_W];
    end
    for (int k = 0; k < rmf_pkg::WIN; k++) begin
      win_next[k*rmf_pkg::WIN] = newcol[k];
      for (int d = 1; d < rmf_pkg::WIN; d++) begin
        win_next[k*rmf_pkg::WIN+d] = win[k*rmf_pkg::WIN+d-1];
      end
    end
  end

  // Center of the result is two rows and two columns behind the new pixel.
  always_comb begin
    hs = $signed({2'b0, geom.h});
    ws = $signed({3'b0, geom.w});
    if (colc >= 12'd2) begin
      r = $signed({2'b0, row}) - 15'sd2;
      c = $signed({3'b0, colc}) - 15'sd2;
    end else if ({1'b0, colc} + {1'b0, geom.w} >= 13'd2) begin
      r = $signed({2'b0, row}) - 15'sd3;
      c = $signed({3'b0, colc}) + ws - 15'sd2;
    end else begin
      r = $signed({2'b0, row}) - 15'sd4;
      c = 15'sd0;
    end
    has_res = (r >= 15'sd0) && (r < hs);
    beyond  = (r >= hs);
    is_last = has_res && (r == hs - 15'sd1) && (c == ws - 15'sd1);
    for (int a = 0; a < rmf_pkg::WIN; a++) begin
      rv[a] = (r + 15'(a) - 15'sd2 >= 15'sd0) && (r + 15'(a) - 15'sd2 < hs);
      cv[a] = (c + 15'(a) - 15'sd2 >= 15'sd0) && (c + 15'(a) - 15'sd2 < ws);
    end
  end

  always_comb begin
    job.last = is_last;
    for (int a = 0; a < rmf_pkg::WIN; a++) begin
      for (int b = 0; b < rmf_pkg::WIN; b++) begin
        job.pix[a*rmf_pkg::WIN+b] = (rv[a] && cv[b]) ?
          win_next[(rmf_pkg::WIN-1-a)*rmf_pkg::WIN + (rmf_pkg::WIN-1-b)] : '0;
      end
    end
  end

  assign push = acc && has_res;
  assign col1 = {1'b0, colc} + 13'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      col   <= '0;
      row   <= '0;
      rd_ok <= 1'b0;
      for (int k = 0; k < rmf_pkg::TAPS; k++) begin
        win[k] <= '0;
      end
    end else if (geom.clr) begin
      col   <= '0;
      row   <= '0;
      rd_ok <= 1'b0;
    end else if (acc) begin
      rd_ok <= 1'b0;
      for (int k = 0; k < rmf_pkg::TAPS; k++) begin
        win[k] <= win_next[k];
      end
      if (beyond || is_last) begin
        col <= '0;
        row <= '0;
      end else if (col1 >= {1'b0, geom.w}) begin
        col <= '0;
        row <= row + 13'd1;
      end else begin
        col <= col1[11:0];
      end
    end else begin
      rd_ok <= 1'b1;
    end
  end

endmodule

// ----- rtl/core/rmf_queue.sv -----
// Short job queue between the front end and the mask evaluator.
module rmf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rmf_pkg::job_t wdata,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output rmf_pkg::job_t rdata
);

  rmf_pkg::job_t mem [rmf_pkg::Q_DEPTH];
  logic [rmf_pkg::Q_AW-1:0] wp, rp;
  logic [rmf_pkg::Q_AW:0]   cnt;

  assign full  = (cnt == (rmf_pkg::Q_AW+1)'(rmf_pkg::Q_DEPTH));
  assign empty = (cnt == '0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == rmf_pkg::Q_AW'(rmf_pkg::Q_DEPTH-1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == rmf_pkg::Q_AW'(rmf_pkg::Q_DEPTH-1)) ? '0 : rp + 1'b1;
      end
      cnt <= cnt + (rmf_pkg::Q_AW+1)'(push) - (rmf_pkg::Q_AW+1)'(pop);
    end
  end

endmodule

// ----- rtl/core/rmf_back.sv -----
// Back end: evaluates the nine masks in turn and divides out the winner's mean.
module rmf_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  rmf_pkg::job_t q_data,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_chan0,
  output logic [7:0]    out_chan1,
  output logic [7:0]    out_chan2,
  output logic          frame_end
);

  localparam int W = rmf_pkg::WIN;

  rmf_pkg::back_state_t st;
  rmf_pkg::pix_t g [rmf_pkg::TAPS];
  logic        last;
  logic [3:0]  m;
  logic [1:0]  co;
  logic [3:0]  div_cnt;

  logic [3:0]  an, cn;
  logic [11:0] as [3];
  logic [19:0] aq [3];
  logic [11:0] cs [3];
  logic [19:0] cq [3];

  logic [25:0] num, bnum, vnum;
  logic [7:0]  den, bden, vden;
  logic [11:0] bs [3];
  logic [3:0]  bn;
  logic [11:0] dv [3];
  logic [11:0] qv [3];
  logic [4:0]  rem [3];
  logic [4:0]  rt [3];
  logic        better;

  assign pop = (st == rmf_pkg::B_IDLE) && !q_empty;

  // Sums over the fixed 3x3 corner of the rotating grid.
  always_comb begin
    an = '0;
    for (int ch = 0; ch < 3; ch++) begin
      as[ch] = '0;
      aq[ch] = '0;
    end
    for (int a = 0; a < rmf_pkg::MASK_EDGE; a++) begin
      for (int b = 0; b < rmf_pkg::MASK_EDGE; b++) begin
        if (g[a*W+b] != '0) begin
          an = an + 4'd1;
          for (int ch = 0; ch < 3; ch++) begin
            as[ch] = as[ch] + 12'(g[a*W+b][8*ch +: 8]);
            aq[ch] = aq[ch] + 20'(g[a*W+b][8*ch +: 8] * g[a*W+b][8*ch +: 8]);
          end
        end
      end
    end
  end

  always_comb begin
    if (cn >= 4'd2) begin
      vnum = '0;
      for (int ch = 0; ch < 3; ch++) begin
        vnum = vnum + 26'(24'(cn * cq[ch]) - 24'(cs[ch] * cs[ch]));
      end
      vden = 8'(8'd3 * 8'(cn) * 8'(cn - 4'd1));
    end else begin
      vnum = 26'(rmf_pkg::LONE_VAR);
      vden = 8'd1;
    end
  end

  assign better = (m == '0) || (34'(num * bden) < 34'(bnum * den));

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      rt[ch] = {rem[ch][3:0], dv[ch][11]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= rmf_pkg::B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((st == rmf_pkg::B_DONE) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (st)
        rmf_pkg::B_IDLE: begin
          if (!q_empty) begin
            for (int k = 0; k < rmf_pkg::TAPS; k++) begin
              g[k] <= q_data.pix[k];
            end
            last <= q_data.last;
            m    <= '0;
            co   <= '0;
            st   <= rmf_pkg::B_ACC;
          end
        end
        rmf_pkg::B_ACC: begin
          cn <= an;
          for (int ch = 0; ch < 3; ch++) begin
            cs[ch] <= as[ch];
            cq[ch] <= aq[ch];
          end
          // Bring the next mask into the corner: one column along, or back
          // to the first column of the next row after the third column.
          for (int a = 0; a < W; a++) begin
            for (int b = 0; b < W; b++) begin
              if (co == 2'd2) begin
                g[a*W+b] <= g[((a+1)%W)*W + (b+3)%W];
              end else begin
                g[a*W+b] <= g[a*W + (b+1)%W];
              end
            end
          end
          co <= (co == 2'd2) ? 2'd0 : co + 2'd1;
          st <= rmf_pkg::B_VAR;
        end
        rmf_pkg::B_VAR: begin
          num <= vnum;
          den <= vden;
          st  <= rmf_pkg::B_CMP;
        end
        rmf_pkg::B_CMP: begin
          if (better) begin
            bnum <= num;
            bden <= den;
            bn   <= cn;
            for (int ch = 0; ch < 3; ch++) begin
              bs[ch] <= cs[ch];
            end
          end
          if (m == 4'(rmf_pkg::MASK_COUNT-1)) begin
            st      <= rmf_pkg::B_DIV;
            div_cnt <= '0;
            for (int ch = 0; ch < 3; ch++) begin
              dv[ch]  <= better ? cs[ch] : bs[ch];
              rem[ch] <= '0;
              qv[ch]  <= '0;
            end
          end else begin
            m  <= m + 4'd1;
            st <= rmf_pkg::B_ACC;
          end
        end
        rmf_pkg::B_DIV: begin
          for (int ch = 0; ch < 3; ch++) begin
            dv[ch] <= {dv[ch][10:0], 1'b0};
            if (rt[ch] >= {1'b0, bn}) begin
              rem[ch] <= rt[ch] - {1'b0, bn};
              qv[ch]  <= {qv[ch][10:0], 1'b1};
            end else begin
              rem[ch] <= rt[ch];
              qv[ch]  <= {qv[ch][10:0], 1'b0};
            end
          end
          div_cnt <= div_cnt + 4'd1;
          if (div_cnt == 4'd11) begin
            st <= rmf_pkg::B_DONE;
          end
        end
        rmf_pkg::B_DONE: begin
          if (!out_valid || out_ready) begin
            out_chan0 <= (bn == '0) ? 8'd0 : qv[0][7:0];
            out_chan1 <= (bn == '0) ? 8'd0 : qv[1][7:0];
            out_chan2 <= (bn == '0) ? 8'd0 : qv[2][7:0];
            frame_end <= last;
            st        <= rmf_pkg::B_IDLE;
          end
        end
        default: begin
          st <= rmf_pkg::B_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/rotating_mask_min_variance_filter.sv -----
// Top level of the rotating mask minimum-variance filter with its register port.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+------------------------------------
//   input    | in_valid / in_ready         | func, chan0, chan1, chan2
//   output   | out_valid / out_ready       | out_chan0..out_chan2, frame_end
//   config   | psel, penable, pwrite       | paddr, pwdata, prdata (pready high)
//
// After each accepted input transaction the front end waits for the registered
// read of the line store at the current column, and it holds in_ready low while
// the job queue is full. In the back end each centered result passes through
// taking the job, the accumulate, variance and compare states for each of nine
// masks, the shift-subtract divider that forms the means, and loading the output
// register. Reset (synchronous, active high) clears the position, the window and
// the queue; the line store holds no reset and needs no clearing pass.
// A job queue of two entries lets the front end keep taking pixels while the
// back end works, and the output register holds a result while out_ready is low.
module rotating_mask_min_variance_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [7:0]  chan0,
  input  logic [7:0]  chan1,
  input  logic [7:0]  chan2,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_chan0,
  output logic [7:0]  out_chan1,
  output logic [7:0]  out_chan2,
  output logic        frame_end,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [11:0] image_width;
  logic [12:0] image_height;
  logic        wr;
  rmf_pkg::geom_t geom;
  rmf_pkg::job_t  push_job, pop_job;
  logic push, pop, q_full, q_empty;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  // Register index is paddr[2]; both registers sit on 32-bit words.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= rmf_pkg::WIDTH_RESET;
      image_height <= rmf_pkg::HEIGHT_RESET;
    end else if (wr) begin
      case (paddr[2])
        rmf_pkg::REG_WIDTH:  image_width  <= pwdata[11:0];
        rmf_pkg::REG_HEIGHT: image_height <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      rmf_pkg::REG_WIDTH:  prdata = {20'd0, image_width};
      rmf_pkg::REG_HEIGHT: prdata = {19'd0, image_height};
      default:             prdata = '0;
    endcase
  end

  // Out-of-range geometry is clamped: zero acts as one, and values past the
  // line store size or the height limit act as those limits.
  always_comb begin
    if (image_width == '0) begin
      geom.w = 12'd1;
    end else if ({2'b0, image_width} > 14'(rmf_pkg::MAX_WIDTH)) begin
      geom.w = 12'(rmf_pkg::MAX_WIDTH);
    end else begin
      geom.w = image_width;
    end
    if (image_height == '0) begin
      geom.h = 13'd1;
    end else if (image_height > 13'(rmf_pkg::HEIGHT_CAP)) begin
      geom.h = 13'(rmf_pkg::HEIGHT_CAP);
    end else begin
      geom.h = image_height;
    end
    // Any register write restarts the frame.
    geom.clr = wr;
  end

  rmf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .geom     (geom),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .chan0    (chan0),
    .chan1    (chan1),
    .chan2    (chan2),
    .q_full   (q_full),
    .push     (push),
    .job      (push_job)
  );

  rmf_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_job),
    .full  (q_full),
    .pop   (pop),
    .empty (q_empty),
    .rdata (pop_job)
  );

  rmf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (pop_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_chan0 (out_chan0),
    .out_chan1 (out_chan1),
    .out_chan2 (out_chan2),
    .frame_end (frame_end)
  );

endmodule

// ----- test/rmf_checker.sv -----
// Scoreboard for the rotating mask filter: mirrors the filter and checks every result.
module rmf_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        func,
  input  logic [7:0]  chan0,
  input  logic [7:0]  chan1,
  input  logic [7:0]  chan2,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_chan0,
  input  logic [7:0]  out_chan1,
  input  logic [7:0]  out_chan2,
  input  logic        frame_end,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          mismatches,
  output int          pending,
  output int          checked
);

  typedef struct {
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic       fe;
  } filtered_pixel_t;

  filtered_pixel_t smoothed_q[$];

  logic [23:0] row_mem [rmf_pkg::LINE_ROWS][rmf_pkg::MAX_WIDTH];
  logic [23:0] nbhd [rmf_pkg::TAPS];
  logic [11:0] col_pos;
  logic [12:0] row_pos;
  logic [11:0] width_reg;
  logic [12:0] height_reg;

  task automatic absorb_pixel(input logic f, input logic [7:0] a, b, c);
    longint w, h, col, row, p, lead, last, q, r, cc0, n, num, den, bnum, bden;
    longint s[3], sq[3];
    logic [7:0] bmean[3];
    logic [23:0] pix, v;
    logic [23:0] newcol[rmf_pkg::WIN];
    longint dy, dx, rr, ccx;
    filtered_pixel_t e;
    w = (width_reg == 0) ? 1 : width_reg;
    if (w > rmf_pkg::MAX_WIDTH) w = rmf_pkg::MAX_WIDTH;
    h = (height_reg == 0) ? 1 : height_reg;
    if (h > rmf_pkg::HEIGHT_CAP) h = rmf_pkg::HEIGHT_CAP;
    col = col_pos;
    row = row_pos;
    if (col >= w) col = 0;
    pix = {c, b, a};
    if (f || row >= h) pix = '0;
    newcol[0] = pix;
    for (int k = 1; k < rmf_pkg::WIN; k++) newcol[k] = row_mem[k-1][col];
    for (int k = rmf_pkg::LINE_ROWS - 1; k > 0; k--) row_mem[k][col] = row_mem[k-1][col];
    row_mem[0][col] = pix;
    for (int k = 0; k < rmf_pkg::WIN; k++) begin
      for (int d = rmf_pkg::WIN - 1; d > 0; d--)
        nbhd[k*rmf_pkg::WIN+d] = nbhd[k*rmf_pkg::WIN+d-1];
      nbhd[k*rmf_pkg::WIN] = newcol[k];
    end
    p = row * w + col;
    col++;
    if (col >= w) begin
      col = 0;
      row++;
    end
    col_pos = col[11:0];
    row_pos = row[12:0];
    lead = 2 * w + 2;
    if (p < lead) return;
    q = p - lead;
    last = h * w - 1;
    if (q > last) begin
      col_pos = '0;
      row_pos = '0;
      return;
    end
    r = q / w;
    cc0 = q % w;
    bnum = 0;
    bden = 1;
    bmean = '{8'd0, 8'd0, 8'd0};
    for (int m = 0; m < rmf_pkg::MASK_COUNT; m++) begin
      n = 0;
      s = '{0, 0, 0};
      sq = '{0, 0, 0};
      for (int ai = 0; ai < rmf_pkg::MASK_EDGE; ai++) begin
        for (int bi = 0; bi < rmf_pkg::MASK_EDGE; bi++) begin
          dy = m / rmf_pkg::MASK_EDGE + ai - 2;
          dx = m % rmf_pkg::MASK_EDGE + bi - 2;
          rr = r + dy;
          ccx = cc0 + dx;
          if (rr < 0 || rr >= h || ccx < 0 || ccx >= w) continue;
          v = nbhd[(2-dy)*rmf_pkg::WIN + (2-dx)];
          if (v == '0) continue;
          n++;
          for (int ch = 0; ch < 3; ch++) begin
            s[ch] += v[8*ch +: 8];
            sq[ch] += v[8*ch +: 8] * v[8*ch +: 8];
          end
        end
      end
      if (n >= 2) begin
        num = 0;
        for (int ch = 0; ch < 3; ch++) num += n * sq[ch] - s[ch] * s[ch];
        den = 3 * n * (n - 1);
      end else begin
        num = rmf_pkg::LONE_VAR;
        den = 1;
      end
      if (m == 0 || num * bden < bnum * den) begin
        bnum = num;
        bden = den;
        for (int ch = 0; ch < 3; ch++) bmean[ch] = (n == 0) ? 8'd0 : 8'(s[ch] / n);
      end
    end
    e.c0 = bmean[0];
    e.c1 = bmean[1];
    e.c2 = bmean[2];
    e.fe = (q == last);
    smoothed_q.push_back(e);
    if (q == last) begin
      col_pos = '0;
      row_pos = '0;
    end
  endtask

  always @(posedge clk) begin
    filtered_pixel_t e;
    if (rst) begin
      for (int k = 0; k < rmf_pkg::TAPS; k++) nbhd[k] = '0;
      col_pos = '0;
      row_pos = '0;
      width_reg = rmf_pkg::WIDTH_RESET;
      height_reg = rmf_pkg::HEIGHT_RESET;
      smoothed_q.delete();
      mismatches = 0;
      checked = 0;
    end else begin
      if (in_valid && in_ready) absorb_pixel(func, chan0, chan1, chan2);
      if (out_valid && out_ready) begin
        if (smoothed_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result %0d %0d %0d fe=%0d",
                     out_chan0, out_chan1, out_chan2, frame_end);
        end else begin
          e = smoothed_q.pop_front();
          checked++;
          if (e.c0 !== out_chan0 || e.c1 !== out_chan1 || e.c2 !== out_chan2 ||
              e.fe !== frame_end) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected %0d %0d %0d fe=%0d, got %0d %0d %0d fe=%0d",
                       checked, e.c0, e.c1, e.c2, e.fe,
                       out_chan0, out_chan1, out_chan2, frame_end);
          end
        end
      end
      if (psel && penable && pwrite) begin
        if (paddr[2] == rmf_pkg::REG_WIDTH) begin
          width_reg = pwdata[11:0];
          col_pos = '0;
          row_pos = '0;
        end else begin
          height_reg = pwdata[12:0];
          col_pos = '0;
          row_pos = '0;
        end
      end
    end
    pending = smoothed_q.size();
  end
endmodule

// ----- test/tb_rotating_mask_min_variance_filter.sv -----
// Stimulus and verdict for the rotating mask filter testbench.
module tb_rotating_mask_min_variance_filter;

  // Generous bound: every result can take the full back end time plus long output stalls.
  localparam int CYCLE_LIMIT = 4000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        func = 1'b0;
  logic [7:0]  chan0 = '0;
  logic [7:0]  chan1 = '0;
  logic [7:0]  chan2 = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_chan0, out_chan1, out_chan2;
  logic        frame_end;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int mismatches, pending, checked;
  int cycles = 0;
  int burst_left = 0;
  int sent = 0;
  int frames = 0;
  int stall_left = 0;
  int stall_mode = 0;
  int cur_w, cur_h;

  always #2 clk = ~clk;

  rotating_mask_min_variance_filter uut (.*);

  rmf_checker scoreboard (
    .clk, .rst, .in_valid, .in_ready, .func, .chan0, .chan1, .chan2,
    .out_valid, .out_ready, .out_chan0, .out_chan1, .out_chan2, .frame_end,
    .psel, .penable, .pwrite, .paddr, .pwdata,
    .mismatches, .pending, .checked
  );

  // The receiver switches between stall styles: always ready, coin flips,
  // rare stalls, and long periodic stalls, each held for a random stretch.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 300);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 7) != 0);
      default: out_ready <= ((cycles % 24) < 5);
    endcase
  end

  // Any run that exceeds the bound is counted as a hang.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // One register write: setup cycle, then the access cycle that commits it.
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Hold the sender off until the filter has delivered everything owed, then
  // give the front end time to retire items that produce no result.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // Set the frame geometry; the order of the two writes is random. The
  // effective sizes are tracked here only to know how long a frame is.
  task automatic set_geometry(input int w, input int h);
    if ($urandom_range(0, 1)) begin
      reg_write({rmf_pkg::REG_WIDTH, 2'b00}, w);
      reg_write({rmf_pkg::REG_HEIGHT, 2'b00}, h);
    end else begin
      reg_write({rmf_pkg::REG_HEIGHT, 2'b00}, h);
      reg_write({rmf_pkg::REG_WIDTH, 2'b00}, w);
    end
    cur_w = (w % 4096 == 0) ? 1 :
            ((w % 4096 > rmf_pkg::MAX_WIDTH) ? rmf_pkg::MAX_WIDTH : w % 4096);
    cur_h = (h % 8192 == 0) ? 1 :
            ((h % 8192 > rmf_pkg::HEIGHT_CAP) ? rmf_pkg::HEIGHT_CAP : h % 8192);
  endtask

  // Present one pixel transaction, taking a random gap between bursts.
  task automatic send_pixel(input logic f, input logic [7:0] a, b, c);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    func <= f;
    chan0 <= a;
    chan1 <= b;
    chan2 <= c;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    sent++;
  endtask

  // A frame of random content. Flat patches make ties between masks, black
  // pixels and padding ticks drop out of masks. A cut frame stops early.
  task automatic random_frame(input int count);
    int base0, base1, base2, spread, pause_at;
    logic [7:0] a, b, c;
    base0 = $urandom_range(0, 255);
    base1 = $urandom_range(0, 255);
    base2 = $urandom_range(0, 255);
    spread = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 255);
    pause_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, count - 1) : -1;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) drain;
      if (spread == 255 || $urandom_range(0, 1)) begin
        a = 8'($urandom_range(0, 255));
        b = 8'($urandom_range(0, 255));
        c = 8'($urandom_range(0, 255));
      end else begin
        a = 8'((base0 + $urandom_range(0, spread)) % 256);
        b = 8'((base1 + $urandom_range(0, spread)) % 256);
        c = 8'((base2 + $urandom_range(0, spread)) % 256);
      end
      if ($urandom_range(0, 7) == 0) {a, b, c} = '0;
      send_pixel($urandom_range(0, 9) == 0, a, b, c);
    end
  endtask

  initial begin
    int count, random_sent;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: a 3x3 image with extreme values, black pixels, padding ticks
    // and a flat region, then a one-pixel frame.
    set_geometry(3, 3);
    send_pixel(1'b0, 8'd255, 8'd255, 8'd255);
    send_pixel(1'b0, 8'd0, 8'd0, 8'd0);
    send_pixel(1'b1, 8'd255, 8'd255, 8'd255);
    send_pixel(1'b0, 8'd255, 8'd0, 8'd1);
    send_pixel(1'b0, 8'd7, 8'd7, 8'd7);
    send_pixel(1'b0, 8'd7, 8'd7, 8'd7);
    send_pixel(1'b0, 8'd7, 8'd7, 8'd7);
    send_pixel(1'b0, 8'd128, 8'd1, 8'd254);
    send_pixel(1'b0, 8'd1, 8'd0, 8'd0);
    for (int i = 0; i < 8; i++) send_pixel(1'b0, 8'd200, 8'd100, 8'd50);
    frames++;
    drain;
    set_geometry(1, 1);
    for (int i = 0; i < 5; i++) send_pixel(1'b0, 8'd99, 8'd98, 8'd97);
    frames++;
    drain;

    // Geometry extremes: zero sizes as a one-pixel frame, then the largest sizes and
    // oversized values, each as a cut frame to keep the run short.
    set_geometry(0, 0);
    for (int i = 0; i < 5; i++) send_pixel(1'b0, 8'd10, 8'd20, 8'd30);
    drain;
    set_geometry(2048, 1);
    random_frame(60);
    drain;
    set_geometry(4095, 1);
    random_frame(60);
    drain;
    set_geometry(1, 4096);
    random_frame(100);
    drain;
    set_geometry(1, 8191);
    random_frame(60);
    drain;

    // Random frames of small sizes, most of them complete.
    random_sent = 0;
    while (random_sent < 950) begin
      set_geometry($urandom_range(0, 4) == 0 ? $urandom_range(1, 40) : $urandom_range(1, 8),
                   $urandom_range(1, 9));
      count = (cur_h + 2) * cur_w + 2;
      if ($urandom_range(0, 5) == 0) count = $urandom_range(1, count);
      else frames++;
      random_frame(count);
      random_sent += count;
      drain;
    end

    $display("Sent %0d pixel transactions in %0d complete frames plus cut frames;", sent, frames);
    $display("checked %0d filtered pixels, with geometry set up to and past its limits.",
             checked);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ----- rotating_mask_min_variance_filter.f -----
rtl/core/rmf_pkg.sv
rtl/core/rmf_ram.sv
rtl/core/rmf_front.sv
rtl/core/rmf_queue.sv
rtl/core/rmf_back.sv
rtl/core/rotating_mask_min_variance_filter.sv
test/rmf_checker.sv
test/tb_rotating_mask_min_variance_filter.sv
